@@ rtl/core/tcs_pkg.sv @@
// shared types and constants for the telnet command stripper
package tcs_pkg;

	localparam logic [7:0] TN_IAC  = 8'd255;
	localparam logic [7:0] TN_DONT = 8'd254;
	localparam logic [7:0] TN_DO   = 8'd253;
	localparam logic [7:0] TN_WONT = 8'd252;
	localparam logic [7:0] TN_WILL = 8'd251;
	localparam logic [7:0] TN_SB   = 8'd250;
	localparam logic [7:0] TN_SE   = 8'd240;

	localparam logic [1:0] K_TEXT = 2'd0;
	localparam logic [1:0] K_PAY  = 2'd1;
	localparam logic [1:0] K_END  = 2'd2;
	localparam logic [1:0] K_CHG  = 2'd3;

	localparam logic [7:0] OPTION_CODE_RESET = 8'd201;
	localparam logic       REG_OPTION_CODE   = 1'b0;

	typedef enum logic [2:0] {
		PH_DATA   = 3'd0,
		PH_IAC    = 3'd1,
		PH_NEG    = 3'd2,
		PH_SBOPT  = 3'd3,
		PH_SBOPTI = 3'd4,
		PH_BODY   = 3'd5,
		PH_BODYI  = 3'd6
	} phase_t;

	// one classified input byte: first result, optional second payload byte
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       two;
		logic       option_on;
	} q_entry_t;

endpackage

@@ rtl/core/tcs_front.sv @@
// front end: telnet parse state machine, classifies each byte and pushes a queue entry for those with a result
module tcs_front import tcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] option_code,
	input  logic       accept,
	input  logic [7:0] in_byte,
	output logic       push,
	output q_entry_t   entry
);

	phase_t     phase_q, phase_nxt;
	logic       neg_enables_q, neg_enables_nxt;
	logic       sub_is_option_q, sub_is_option_nxt;
	logic       option_enabled_q, option_enabled_nxt;
	logic       want;
	logic       is_verb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_DATA;
			neg_enables_q    <= 1'b0;
			sub_is_option_q  <= 1'b0;
			option_enabled_q <= 1'b0;
		end else if (accept) begin
			phase_q          <= phase_nxt;
			neg_enables_q    <= neg_enables_nxt;
			sub_is_option_q  <= sub_is_option_nxt;
			option_enabled_q <= option_enabled_nxt;
		end
	end

	assign is_verb = (in_byte == TN_WILL) || (in_byte == TN_WONT) ||
	                 (in_byte == TN_DO) || (in_byte == TN_DONT);

	always_comb begin
		phase_nxt          = phase_q;
		neg_enables_nxt    = neg_enables_q;
		sub_is_option_nxt  = sub_is_option_q;
		option_enabled_nxt = option_enabled_q;
		want               = 1'b0;
		entry.kind         = K_TEXT;
		entry.byte0        = in_byte;
		entry.byte1        = in_byte;
		entry.two          = 1'b0;
		case (phase_q)
			PH_IAC: begin
				if (in_byte == TN_IAC) begin
					want        = 1'b1;
					entry.kind  = K_TEXT;
					entry.byte0 = TN_IAC;
					phase_nxt   = PH_DATA;
				end else if (is_verb) begin
					neg_enables_nxt = (in_byte == TN_WILL) || (in_byte == TN_DO);
					phase_nxt       = PH_NEG;
				end else if (in_byte == TN_SB) begin
					phase_nxt = PH_SBOPT;
				end else begin
					phase_nxt = PH_DATA;
				end
			end
			PH_NEG: begin
				phase_nxt = PH_DATA;
				if ((in_byte == option_code) && (option_enabled_q != neg_enables_q)) begin
					option_enabled_nxt = neg_enables_q;
					want               = 1'b1;
					entry.kind         = K_CHG;
					entry.byte0        = 8'd0;
				end
			end
			PH_SBOPT: begin
				sub_is_option_nxt = (in_byte == option_code);
				phase_nxt         = (in_byte == TN_IAC) ? PH_SBOPTI : PH_BODY;
			end
			PH_SBOPTI, PH_BODY: begin
				if ((phase_q == PH_SBOPTI) && (in_byte == TN_SE)) begin
					want        = sub_is_option_q;
					entry.kind  = K_END;
					entry.byte0 = 8'd0;
					phase_nxt   = PH_DATA;
				end else if (in_byte == TN_IAC) begin
					phase_nxt = PH_BODYI;
				end else begin
					want       = sub_is_option_q;
					entry.kind = K_PAY;
					phase_nxt  = PH_BODY;
				end
			end
			PH_BODYI: begin
				if (in_byte == TN_SE) begin
					want        = sub_is_option_q;
					entry.kind  = K_END;
					entry.byte0 = 8'd0;
					phase_nxt   = PH_DATA;
				end else begin
					// held iac goes out as payload, then the current byte unless it is an iac, which is held in turn
					want        = sub_is_option_q;
					entry.kind  = K_PAY;
					entry.byte0 = TN_IAC;
					if (in_byte == TN_IAC) begin
						phase_nxt = PH_BODYI;
					end else begin
						entry.two = 1'b1;
						phase_nxt = PH_BODY;
					end
				end
			end
			default: begin
				if (in_byte == TN_IAC) begin
					phase_nxt = PH_IAC;
				end else begin
					want       = 1'b1;
					entry.kind = K_TEXT;
					phase_nxt  = PH_DATA;
				end
			end
		endcase
		entry.option_on = option_enabled_nxt;
		push            = accept && want;
	end

endmodule

@@ rtl/core/tcs_queue.sv @@
// short fifo of classified entries between front and back
module tcs_queue import tcs_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	input  logic     pop,
	output logic     full,
	output logic     not_empty,
	output q_entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/tcs_back.sv @@
// back end: expands queue entries into output beats through an output register
module tcs_back import tcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  q_entry_t    q_head,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic       option_on_q;
	logic       last_q;
	logic       pend_q;
	logic [7:0] pend_byte_q;
	logic       pend_opt_q;
	logic       out_free;

	assign out_free = !valid_q || m_tready;
	assign q_pop    = out_free && !pend_q && q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= q_not_empty;
				pend_q  <= q_not_empty && q_head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				kind_q      <= K_PAY;
				byte_q      <= pend_byte_q;
				option_on_q <= pend_opt_q;
				last_q      <= 1'b1;
			end else if (q_not_empty) begin
				kind_q      <= q_head.kind;
				byte_q      <= q_head.byte0;
				option_on_q <= q_head.option_on;
				last_q      <= !q_head.two;
				pend_byte_q <= q_head.byte1;
				pend_opt_q  <= q_head.option_on;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {7'd0, option_on_q, byte_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

@@ rtl/core/telnet_command_stripper_top.sv @@
// top level of the telnet command stripper: config register, front, queue, back
// takes one byte per cycle while the queue has room; s_tready drops only when it is full
// first result beat of a byte is written into the queue, then loaded into the back end output register
// the back end gives one beat per cycle while m_tready is high, so a byte with two results occupies it for two beats
// asynchronous active-low reset: parser to data phase, option off, queue and output empty
// option_code resets to 201
module telnet_command_stripper_top import tcs_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_byte [7:0], option_on [8], zero [15:9]
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast    // last
);

	logic [7:0] option_code_q;
	logic       q_full;
	logic       q_not_empty;
	logic       q_pop;
	logic       push;
	logic       accept;
	q_entry_t   entry;
	q_entry_t   q_head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			option_code_q <= OPTION_CODE_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_OPTION_CODE)) begin
			option_code_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_OPTION_CODE) ? {24'd0, option_code_q} : 32'd0;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	tcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.option_code (option_code_q),
		.accept      (accept),
		.in_byte     (s_tdata),
		.push        (push),
		.entry       (entry)
	);

	tcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (q_pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	tcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

@@ rtl/core/tcs_checker.sv @@
// port-level checks for the telnet command stripper, bound to the top level
module tcs_checker import tcs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output beat changed while stalled");

	// end and change beats carry a zero byte
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == K_END || m_tuser == K_CHG) |-> m_tdata[7:0] == 8'd0)
		else $error("end or change beat with nonzero byte");

	// only a held iac payload byte is followed by another beat of the same input byte
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == K_PAY && m_tdata[7:0] == TN_IAC)
		else $error("non-final beat is not an iac payload byte");

	// the beat after a non-final one is a payload beat that closes the pair
	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast && m_tuser == K_PAY
			&& m_tdata[8] == $past(m_tdata[8]))
		else $error("second beat of a pair missing or wrong");

endmodule

bind telnet_command_stripper_top tcs_checker u_tcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
